@@ rtl/sawf_pkg.sv @@
// ----------------------------------------------------------------------------
// sawf_pkg
// Types, constants and fixed-point helpers shared by the segmented ARMA
// whitening filter and its checker.
// ----------------------------------------------------------------------------
package sawf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INNOV_W    = 20;
    localparam int COLIN_W    = 6;
    localparam int COEF_W     = 16;
    localparam int COEF_LANES = 4;
    localparam int ORDER_W    = 3;
    localparam int GAIN_W     = 16;
    localparam int CNT_W      = 3;
    localparam int MUL_A_W    = COEF_W + 1;
    localparam int MUL_B_W    = INNOV_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W * COEF_LANES;
    localparam int COL_ENTRIES = 1 << COLIN_W;

    localparam logic [CNT_W-1:0] HIST_MAX = 3'd4;

    localparam logic signed [ACC_W-1:0] ACC_INNOV_MAX = 26'sd524287;
    localparam logic signed [ACC_W-1:0] ACC_INNOV_MIN = -26'sd524288;
    localparam logic signed [INNOV_W-1:0] INNOV_MAX = 20'sh7FFFF;
    localparam logic signed [INNOV_W-1:0] INNOV_MIN = 20'sh80000;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AR_COEF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MA_COEF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AR_ORDER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MA_ORDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [COLIN_W-1:0]         in_column;
        logic                       segment_start;
    } in_word_t;

    typedef struct packed {
        logic signed [INNOV_W-1:0] innovation;
        logic [COLIN_W-1:0]        out_column;
        logic                      saturated;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SAT,
        ST_SCL_MUL,
        ST_SCL_RND,
        ST_SCL_SAT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_SUB,
        MAC_SCALE
    } mac_op_t;

    typedef struct packed {
        logic    mul_en;
        mac_op_t op;
    } mac_ctrl_t;

    // round a product to nearest, ties away from zero, by 2^14 or 2^15
    function automatic logic signed [ACC_W-1:0] round_prod(
        input logic signed [PROD_W-1:0] p,
        input logic                     by15
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sum;
        logic [PROD_W-1:0] shr;
        logic [ACC_W-1:0]  r;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        sum = by15 ? mag + PROD_W'(1 << 14) : mag + PROD_W'(1 << 13);
        shr = by15 ? (sum >> 15) : (sum >> 14);
        r   = shr[ACC_W-1:0];
        return p[PROD_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [INNOV_W-1:0] clip_innov(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [INNOV_W-1:0] r;
        if (v > ACC_INNOV_MAX)
            r = INNOV_MAX;
        else if (v < ACC_INNOV_MIN)
            r = INNOV_MIN;
        else
            r = v[INNOV_W-1:0];
        return r;
    endfunction

    function automatic logic over_innov(input logic signed [ACC_W-1:0] v);
        return (v > ACC_INNOV_MAX) || (v < ACC_INNOV_MIN);
    endfunction

endpackage

@@ rtl/sawf_mac.sv @@
// ----------------------------------------------------------------------------
// sawf_mac
// Shared multiply, round and accumulate unit: one registered product, then a
// rounded subtract, rounded load or plain initial load into the accumulator.
// ----------------------------------------------------------------------------
module sawf_mac (
    input  logic                                  clk,
    input  sawf_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [sawf_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [sawf_pkg::MUL_B_W-1:0]   op_b,
    input  logic signed [sawf_pkg::ACC_W-1:0]     init_val,
    output logic signed [sawf_pkg::ACC_W-1:0]     acc
);
    import sawf_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod = op_a * op_b;

    always_comb
    begin
        case (ctrl.op)
            MAC_LOAD:  acc_next = init_val;
            MAC_SUB:   acc_next = acc_reg - round_prod(prod_reg, 1'b0);
            MAC_SCALE: acc_next = round_prod(prod_reg, 1'b1);
            default:   acc_next = acc_reg;
        endcase
    end

    // inactive taps feed a zero product so the subtract is a no-op
    always_ff @(posedge clk)
    begin
        prod_reg <= ctrl.mul_en ? prod : '0;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ rtl/segmented_arma_whitening_filter.sv @@
// ----------------------------------------------------------------------------
// segmented_arma_whitening_filter
// Per-column ARMA prewhitening filter with segment-aware history, Q2.14
// coefficients, 20-bit saturated innovations and optional first-sample gain.
// ----------------------------------------------------------------------------
//  channel | signals                        | word
//  --------+--------------------------------+-----------------------------
//  in      | in_valid, in_ready, in_data    | sample, in_column, seg start
//  out     | out_valid, out_ready, out_data | innovation, column, saturated
//  cfg     | cfg_we, cfg_index, cfg_data    | register write, no read-back
//
//  an item steps the shared multiply-accumulate once per tap, then rounds,
//  saturates and writes the column history back; when the first-sample gain
//  applies, a multiply, round and saturate pass follows.
//  after reset a clearing pass over every row zeroes the history counts;
//  in_ready stays low during it.
//  a finished word waits in the output register; a new word is taken meanwhile.
// ----------------------------------------------------------------------------
module segmented_arma_whitening_filter #(
    parameter int AR_TAPS = 4,
    parameter int MA_TAPS = 4,
    parameter int COLUMNS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  sawf_pkg::in_word_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output sawf_pkg::out_word_t                   out_data,
    input  logic                                  cfg_we,
    input  logic [sawf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sawf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sawf_pkg::*;

    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int TAPS     = AR_TAPS + MA_TAPS;
    localparam int STEP_W   = $clog2(TAPS);
    localparam int AR_IDX_W = (AR_TAPS > 1) ? $clog2(AR_TAPS) : 1;
    localparam int MA_IDX_W = (MA_TAPS > 1) ? $clog2(MA_TAPS) : 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] ar_coef_reg;
    logic [CFG_DATA_W-1:0] ma_coef_reg;
    logic [ORDER_W-1:0]    ar_order_reg;
    logic [ORDER_W-1:0]    ma_order_reg;
    logic                  exact_reg;
    logic [GAIN_W-1:0]     gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_coef_reg  <= '0;
            ma_coef_reg  <= '0;
            ar_order_reg <= '0;
            ma_order_reg <= '0;
            exact_reg    <= 1'b0;
            gain_reg     <= GAIN_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AR_COEF:    ar_coef_reg  <= cfg_data;
                CFG_MA_COEF:    ma_coef_reg  <= cfg_data;
                CFG_AR_ORDER:   ar_order_reg <= cfg_data[ORDER_W-1:0];
                CFG_MA_ORDER:   ma_order_reg <= cfg_data[ORDER_W-1:0];
                CFG_EXACT:      exact_reg    <= cfg_data[0];
                CFG_FIRST_GAIN: gain_reg     <= cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // column folding table
    logic [COL_W-1:0] col_lut [COL_ENTRIES];

    for (genvar gi = 0; gi < COL_ENTRIES; gi++)
    begin : g_col_lut
        assign col_lut[gi] = COL_W'(gi % COLUMNS);
    end

    // history memories, one row per column
    logic [CNT_W-1:0]                cnt_mem [COLUMNS];
    logic [AR_TAPS-1:0][SAMPLE_W-1:0] smp_mem [COLUMNS];
    logic [MA_TAPS-1:0][INNOV_W-1:0]  inn_mem [COLUMNS];

    logic [CNT_W-1:0]                 cnt_rd_reg;
    logic [AR_TAPS-1:0][SAMPLE_W-1:0] smp_rd_reg;
    logic [MA_TAPS-1:0][INNOV_W-1:0]  inn_rd_reg;

    logic                             mem_we;
    logic [COL_W-1:0]                 mem_wa;
    logic [CNT_W-1:0]                 cnt_wd;
    logic [AR_TAPS-1:0][SAMPLE_W-1:0] smp_wd;
    logic [MA_TAPS-1:0][INNOV_W-1:0]  inn_wd;
    logic                             rd_en;
    logic [COL_W-1:0]                 rd_addr;

    // sequencer and item registers
    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [COL_W-1:0]          clr_idx_reg, clr_idx_next;
    logic                      out_valid_reg;
    out_word_t                 out_data_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [COLIN_W-1:0]         column_reg;
    logic [COL_W-1:0]           col_reg;
    logic                       seg_reg;
    logic signed [INNOV_W-1:0]  inn_reg;
    logic signed [INNOV_W-1:0]  res_reg;
    logic                       sat_reg;
    logic                       scale_reg;

    logic                       accept;
    logic                       out_load;
    logic [CNT_W-1:0]           cnt_eff;
    logic [ORDER_W-1:0]         ar_p;
    logic [ORDER_W-1:0]         ma_q;
    logic [AR_IDX_W-1:0]        ar_idx;
    logic [MA_IDX_W-1:0]        ma_idx;
    logic                       tap_active;
    logic                       exact_hit;

    mac_ctrl_t                  mac_ctrl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    acc_init;
    logic signed [ACC_W-1:0]    acc;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign rd_en    = accept;
    assign rd_addr  = col_lut[in_data.in_column];

    assign cnt_eff = seg_reg ? '0 : cnt_rd_reg;
    assign ar_p    = (ar_order_reg < ORDER_W'(AR_TAPS)) ? ar_order_reg : ORDER_W'(AR_TAPS);
    assign ma_q    = (ma_order_reg < ORDER_W'(MA_TAPS)) ? ma_order_reg : ORDER_W'(MA_TAPS);
    assign ar_idx  = step_reg[AR_IDX_W-1:0];
    assign ma_idx  = MA_IDX_W'(step_reg - STEP_W'(AR_TAPS));
    assign exact_hit = exact_reg && (ar_order_reg == ORDER_W'(1)) &&
                       (ma_order_reg == '0) && (cnt_eff == '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_wa] <= cnt_wd;
            smp_mem[mem_wa] <= smp_wd;
            inn_mem[mem_wa] <= inn_wd;
        end
        if (rd_en)
        begin
            cnt_rd_reg <= cnt_mem[rd_addr];
            smp_rd_reg <= smp_mem[rd_addr];
            inn_rd_reg <= inn_mem[rd_addr];
        end
    end

    // shifted history for write-back; the clearing pass only cares about the count
    always_comb
    begin
        smp_wd[0] = sample_reg;
        for (int k = 1; k < AR_TAPS; k++)
            smp_wd[k] = smp_rd_reg[k-1];
        inn_wd[0] = inn_reg;
        for (int k = 1; k < MA_TAPS; k++)
            inn_wd[k] = inn_rd_reg[k-1];
        if (state_reg == ST_CLEAR)
        begin
            cnt_wd = '0;
            mem_wa = clr_idx_reg;
        end
        else
        begin
            cnt_wd = (cnt_eff < HIST_MAX) ? cnt_eff + CNT_W'(1) : HIST_MAX;
            mem_wa = col_reg;
        end
    end

    // operand select for the shared unit
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        tap_active = 1'b0;
        acc_init   = {{(ACC_W-SAMPLE_W){in_data.sample[SAMPLE_W-1]}}, in_data.sample};
        if (state_reg == ST_SCL_MUL)
        begin
            mul_a = $signed({1'b0, gain_reg});
            mul_b = inn_reg;
        end
        else if (step_reg < STEP_W'(AR_TAPS))
        begin
            mul_a = {ar_coef_reg[COEF_W*ar_idx + COEF_W - 1],
                     ar_coef_reg[COEF_W*ar_idx +: COEF_W]};
            mul_b = {{(INNOV_W-SAMPLE_W){smp_rd_reg[ar_idx][SAMPLE_W-1]}},
                     smp_rd_reg[ar_idx]};
            tap_active = (ORDER_W'(ar_idx) < ar_p) && (CNT_W'(ar_idx) < cnt_eff);
        end
        else
        begin
            mul_a = {ma_coef_reg[COEF_W*ma_idx + COEF_W - 1],
                     ma_coef_reg[COEF_W*ma_idx +: COEF_W]};
            mul_b = inn_rd_reg[ma_idx];
            tap_active = (ORDER_W'(ma_idx) < ma_q) && (CNT_W'(ma_idx) < cnt_eff);
        end
    end

    sawf_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .init_val (acc_init),
        .acc      (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_idx_reg <= clr_idx_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_idx_next = clr_idx_reg;
        mem_we       = 1'b0;
        mac_ctrl     = '{mul_en: 1'b0, op: MAC_HOLD};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + COL_W'(1);
                if (clr_idx_reg == COL_W'(COLUMNS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    mac_ctrl.op = MAC_LOAD;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC:
            begin
                // product of the previous tap is subtracted while this one multiplies
                mac_ctrl.mul_en = tap_active;
                mac_ctrl.op     = (step_reg == '0) ? MAC_HOLD : MAC_SUB;
                step_next       = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TAPS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                mac_ctrl.op = MAC_SUB;
                state_next  = ST_SAT;
            end
            ST_SAT:
            begin
                state_next = exact_hit ? ST_SCL_MUL : ST_DONE;
            end
            ST_SCL_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                state_next      = ST_SCL_RND;
            end
            ST_SCL_RND:
            begin
                mac_ctrl.op = MAC_SCALE;
                state_next  = ST_SCL_SAT;
            end
            ST_SCL_SAT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_data.sample;
            column_reg <= in_data.in_column;
            col_reg    <= rd_addr;
            seg_reg    <= in_data.segment_start;
        end
        if (state_reg == ST_SAT)
        begin
            inn_reg   <= clip_innov(acc);
            res_reg   <= clip_innov(acc);
            sat_reg   <= over_innov(acc);
            scale_reg <= exact_hit;
        end
        if (state_reg == ST_SCL_SAT && scale_reg)
        begin
            res_reg <= clip_innov(acc);
            sat_reg <= sat_reg | over_innov(acc);
        end
        if (out_load)
        begin
            out_data_reg.innovation <= res_reg;
            out_data_reg.out_column <= column_reg;
            out_data_reg.saturated  <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/sawf_checker.sv @@
// ----------------------------------------------------------------------------
// sawf_checker
// Port-level checks for the segmented ARMA whitening filter, bound to the top.
// ----------------------------------------------------------------------------
module sawf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  sawf_pkg::out_word_t out_data
);
    import sawf_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed or dropped while stalled");

    // one word in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while a word is in flight");

    // a new result frees the input side in the same cycle
    a_rose_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while input still blocked");

    // the tap loop keeps a result from appearing right after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared too soon after accept");

endmodule

bind segmented_arma_whitening_filter sawf_checker u_sawf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ dv/segmented_arma_whitening_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_arma_whitening_filter_tb
// Drives sample words with random gaps and back-pressure, and predicts every
// innovation from its own per-column filter state. It checks each output word
// against the oldest prediction, across several coefficient and order settings.
// ----------------------------------------------------------------------------
module segmented_arma_whitening_filter_tb;
    import sawf_pkg::*;

    localparam int NUM_COLS      = 64;
    localparam int NUM_TAPS      = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 183;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam longint SUM_MAX = 524287;
    localparam longint SUM_MIN = -524288;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // filter state as the block should hold it
    logic [CFG_DATA_W-1:0]      cur_ar_coefs;
    logic [CFG_DATA_W-1:0]      cur_ma_coefs;
    logic [ORDER_W-1:0]         cur_ar_order;
    logic [ORDER_W-1:0]         cur_ma_order;
    logic                       cur_exact;
    logic [GAIN_W-1:0]          cur_gain;
    logic signed [SAMPLE_W-1:0] past_samples [NUM_COLS][NUM_TAPS];
    logic signed [INNOV_W-1:0]  past_innovs  [NUM_COLS][NUM_TAPS];
    int unsigned                seg_len      [NUM_COLS];

    in_word_t    pending_words[$];
    out_word_t   expected_words[$];
    out_word_t   want_word;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    int          mismatches = 0;
    bit          gaps_on    = 1'b1;
    bit          stalls_on  = 1'b1;

    segmented_arma_whitening_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic longint coef_at(logic [CFG_DATA_W-1:0] coefs, int lane);
        logic signed [COEF_W-1:0] c;
        c = coefs[lane*COEF_W +: COEF_W];
        return longint'(c);
    endfunction

    // nearest, ties away from zero
    function automatic longint round_away(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_innov(longint v);
        if (v > SUM_MAX)
            return SUM_MAX;
        if (v < SUM_MIN)
            return SUM_MIN;
        return v;
    endfunction

    function automatic out_word_t whiten(in_word_t w);
        int          col;
        int          k;
        int unsigned depth;
        int unsigned nar;
        int unsigned nma;
        longint      x;
        longint      acc;
        longint      inn;
        longint      res;
        logic        clipped;
        out_word_t   r;
        col = int'(w.in_column) % NUM_COLS;
        x   = longint'(w.sample);
        nar = (cur_ar_order < NUM_TAPS) ? cur_ar_order : NUM_TAPS;
        nma = (cur_ma_order < NUM_TAPS) ? cur_ma_order : NUM_TAPS;
        if (w.segment_start)
            seg_len[col] = 0;
        depth = seg_len[col];
        acc = x;
        for (k = 0; k < NUM_TAPS; k++)
        begin
            if (k < nar && k < depth)
                acc -= round_away(coef_at(cur_ar_coefs, k) * past_samples[col][k], 14);
            if (k < nma && k < depth)
                acc -= round_away(coef_at(cur_ma_coefs, k) * past_innovs[col][k], 14);
        end
        clipped = (acc > SUM_MAX) || (acc < SUM_MIN);
        inn = clamp_innov(acc);
        res = inn;
        // pure ar(1) segment head gets the software gain
        if (cur_exact && cur_ar_order == 3'd1 && cur_ma_order == 3'd0 && depth == 0)
        begin
            res = round_away(inn * longint'(cur_gain), 15);
            clipped = clipped || (res > SUM_MAX) || (res < SUM_MIN);
            res = clamp_innov(res);
        end
        for (k = NUM_TAPS - 1; k > 0; k--)
        begin
            past_samples[col][k] = past_samples[col][k-1];
            past_innovs[col][k]  = past_innovs[col][k-1];
        end
        past_samples[col][0] = w.sample;
        past_innovs[col][0]  = inn[INNOV_W-1:0];
        if (depth < NUM_TAPS)
            seg_len[col] = depth + 1;
        r.innovation = res[INNOV_W-1:0];
        r.out_column = w.in_column;
        r.saturated  = clipped;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_word_t mk_word(logic signed [SAMPLE_W-1:0] s,
                                         logic [COLIN_W-1:0] c, logic st);
        in_word_t w;
        w.sample        = s;
        w.in_column     = c;
        w.segment_start = st;
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            4:       return SAMPLE_W'($urandom_range(0, 255) - 128);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly runs on a few columns so segments build up history
    function automatic in_word_t random_word(int unsigned base, int unsigned span,
                                             int unsigned seg_odds);
        logic [COLIN_W-1:0] c;
        if ($urandom_range(0, 9) == 0)
            c = COLIN_W'($urandom);
        else
            c = COLIN_W'(base + $urandom_range(0, span - 1));
        return mk_word(pick_sample(), c, $urandom_range(0, seg_odds) == 0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coefs();
        logic [CFG_DATA_W-1:0] v;
        int                    k;
        case ($urandom_range(0, 6))
            0: v = {$urandom, $urandom};
            1: v = {NUM_TAPS{16'h7FFF}};
            2: v = {NUM_TAPS{16'h8000}};
            3: v = '0;
            default:
            begin
                v = '0;
                for (k = 0; k < NUM_TAPS; k++)
                    v[k*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 12000) - 6000);
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_AR_COEF:    cur_ar_coefs = val;
            CFG_MA_COEF:    cur_ma_coefs = val;
            CFG_AR_ORDER:   cur_ar_order = val[ORDER_W-1:0];
            CFG_MA_ORDER:   cur_ma_order = val[ORDER_W-1:0];
            CFG_EXACT:      cur_exact    = val[0];
            CFG_FIRST_GAIN: cur_gain     = val[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_config(int unsigned ph);
        logic [ORDER_W-1:0] aro;
        logic [ORDER_W-1:0] mao;
        logic               ex;
        logic [GAIN_W-1:0]  g;
        aro = ORDER_W'($urandom_range(0, 7));
        mao = ORDER_W'($urandom_range(0, 7));
        ex  = 1'($urandom_range(0, 1));
        if (ph == 0 || $urandom_range(0, 2) == 0)
        begin
            aro = 3'd1;
            mao = 3'd0;
            ex  = 1'b1;
        end
        if (ph == 1)
        begin
            aro = 3'd4;
            mao = 3'd4;
        end
        case ($urandom_range(0, 4))
            0:       g = '0;
            1:       g = GAIN_ONE;
            2:       g = '1;
            default: g = GAIN_W'($urandom);
        endcase
        if (ph == 0)
            g = '0;
        write_reg(CFG_AR_COEF, pick_coefs());
        write_reg(CFG_MA_COEF, pick_coefs());
        write_reg(CFG_AR_ORDER, CFG_DATA_W'(aro));
        write_reg(CFG_MA_ORDER, CFG_DATA_W'(mao));
        write_reg(CFG_EXACT, CFG_DATA_W'(ex));
        write_reg(CFG_FIRST_GAIN, CFG_DATA_W'(g));
    endtask

    // sample side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_words.push_back(whiten(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_words.pop_front();
                    gap_left <= gaps_on ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // innovation side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no word, got %0d col=%0d sat=%0b",
                             $time, out_data.innovation, out_data.out_column,
                             out_data.saturated);
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (out_data.innovation !== want_word.innovation ||
                        out_data.out_column !== want_word.out_column ||
                        out_data.saturated  !== want_word.saturated)
                    begin
                        mismatches++;
                        $display("%0t: expected %0d col=%0d sat=%0b, got %0d col=%0d sat=%0b",
                                 $time, want_word.innovation, want_word.out_column,
                                 want_word.saturated, out_data.innovation,
                                 out_data.out_column, out_data.saturated);
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= pick_gap();
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[segmented_arma_whitening_filter] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        else
            quiet_cycles <= 0;
    end

    initial
    begin
        int          ph;
        int          n;
        int          c;
        int          k;
        int unsigned base;
        int unsigned span;
        int unsigned seg_odds;
        cur_ar_coefs = '0;
        cur_ma_coefs = '0;
        cur_ar_order = '0;
        cur_ma_order = '0;
        cur_exact    = 1'b0;
        cur_gain     = GAIN_ONE;
        for (c = 0; c < NUM_COLS; c++)
        begin
            seg_len[c] = 0;
            for (k = 0; k < NUM_TAPS; k++)
            begin
                past_samples[c][k] = '0;
                past_innovs[c][k]  = '0;
            end
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: plain pass-through, first word without a start flag
        pending_words.push_back(mk_word(16'sh7FFF, 6'd0, 1'b0));
        pending_words.push_back(mk_word(16'sh8000, 6'd63, 1'b1));
        pending_words.push_back(mk_word(16'sh0000, 6'd0, 1'b0));
        pending_words.push_back(mk_word(16'shFFFF, 6'd63, 1'b0));
        wait_drained();

        // pure ar(1) with gain near 2.0, half tap gives a rounding tie
        write_reg(CFG_AR_COEF, 64'h7FFF_8000_C000_2000);
        write_reg(CFG_MA_COEF, 64'h0000_0000_0000_0000);
        write_reg(CFG_AR_ORDER, 64'd1);
        write_reg(CFG_MA_ORDER, 64'd0);
        write_reg(CFG_EXACT, 64'd1);
        write_reg(CFG_FIRST_GAIN, 64'hFFFF);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, '1);
        @(negedge clk);
        pending_words.push_back(mk_word(16'sh7FFF, 6'd5, 1'b1));
        pending_words.push_back(mk_word(16'sh8000, 6'd5, 1'b0));
        pending_words.push_back(mk_word(16'sh8000, 6'd5, 1'b1));
        pending_words.push_back(mk_word(16'sh0001, 6'd9, 1'b0));
        pending_words.push_back(mk_word(16'sh0000, 6'd5, 1'b0));
        wait_drained();

        // orders above the tap count and -2.0 taps drive the sum into clipping
        write_reg(CFG_AR_COEF, {NUM_TAPS{16'h8000}});
        write_reg(CFG_MA_COEF, {NUM_TAPS{16'h8000}});
        write_reg(CFG_AR_ORDER, 64'd7);
        write_reg(CFG_MA_ORDER, 64'd5);
        write_reg(CFG_FIRST_GAIN, 64'd0);
        @(negedge clk);
        for (n = 0; n < 5; n++)
        begin
            pending_words.push_back(mk_word(16'sh7FFF, 6'd20, n == 0));
            pending_words.push_back(mk_word(16'sh8000, 6'd41, n == 0));
        end
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_config(ph);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            base      = $urandom_range(0, NUM_COLS - 1);
            span      = $urandom_range(1, 6);
            case ($urandom_range(0, 2))
                0:       seg_odds = 3;
                1:       seg_odds = 12;
                default: seg_odds = 40;
            endcase
            @(negedge clk);
            for (n = 0; n < PHASE_WORDS; n++)
                pending_words.push_back(random_word(base, span, seg_odds));
            wait_drained();
        end

        if (mismatches == 0)
            $display("[segmented_arma_whitening_filter] OK");
        else
            $display("[segmented_arma_whitening_filter] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sawf_pkg.sv
rtl/sawf_mac.sv
rtl/segmented_arma_whitening_filter.sv
rtl/sawf_checker.sv
dv/segmented_arma_whitening_filter_tb.sv
